[src/assert_macros.svh]
// Assertion macros shared by the page store RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check, masked while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Clocked check that also runs through reset.
`define ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NORST(label, clk, prop)

`endif

`endif

[src/lpr_pkg.sv]
// Shared constants, types and helpers for the LRU page store.
// No dependencies; every RTL module imports this package.
package lpr_pkg;

    localparam int ENTRIES       = 16;
    localparam int PAGE_BITS     = 20;
    localparam int SLOT_BITS     = $clog2(ENTRIES);
    localparam int RANK_BITS     = SLOT_BITS;
    localparam int CNT_BITS      = $clog2(ENTRIES + 1);
    localparam int ACT_BITS      = 5;
    localparam int SLOT_OUT_BITS = 4;
    localparam int STAT_BITS     = 32;
    localparam int ACT_RESET     = 16;

    typedef logic [SLOT_BITS-1:0]     slot_t;
    typedef logic [PAGE_BITS-1:0]     page_t;
    typedef logic [RANK_BITS-1:0]     rank_t;
    typedef logic [CNT_BITS-1:0]      cnt_t;
    typedef logic [ACT_BITS-1:0]      act_t;
    typedef logic [SLOT_OUT_BITS-1:0] slot_out_t;
    typedef logic [STAT_BITS-1:0]     stat_t;

    // ranks saturate at the oldest position the store can hold
    localparam rank_t RANK_MAX = rank_t'(ENTRIES - 1);

    // One slot as seen through the store's read port
    typedef struct packed {
        logic  valid;
        page_t tag;
        rank_t rank;
    } entry_rd_t;

    // Commit of one access into the store
    typedef struct packed {
        logic  en;
        logic  hit;
        slot_t slot;
        page_t page;
        cnt_t  n;
    } upd_cmd_t;

    // What the scan found over the active slots
    typedef struct packed {
        logic  hit;
        slot_t hit_idx;
        logic  empty;
        slot_t empty_idx;
        slot_t best_idx;
    } scan_res_t;

    function automatic slot_out_t to_slot_out(slot_t s);
        logic [SLOT_BITS+SLOT_OUT_BITS-1:0] w;
        w = {{SLOT_OUT_BITS{1'b0}}, s};
        return w[SLOT_OUT_BITS-1:0];
    endfunction

endpackage

[src/lru_page_replacement.sv]
// Fully associative page store with true LRU replacement.
// Operation: an accepted beat scans one slot per cycle (stops early on a hit)
// through the single-slot scan port of the store, then an update state that
// waits for the output to be free; one access is in flight at a time, and a
// new beat is taken only when the block is idle.
// Reset (aresetn low, synchronous): valid marks, ranks and counters clear,
// active_entries returns to 16; no clearing pass.
`include "assert_macros.svh"

module lru_page_replacement (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  lpr_pkg::page_t          s_page,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_hit,
    output lpr_pkg::slot_out_t      m_slot,
    output logic                    m_evicted_valid,
    output lpr_pkg::page_t          m_evicted_page,
    output lpr_pkg::stat_t          m_hits_so_far,
    output lpr_pkg::stat_t          m_accesses_so_far,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  lpr_pkg::act_t           cfg_data
);
    import lpr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    state_t    state_reg, state_next;
    slot_t     idx_reg;
    page_t     page_reg;
    act_t      act_reg;
    stat_t     hit_cnt_reg, acc_cnt_reg;
    logic      m_valid_reg;
    logic      m_hit_reg;
    slot_out_t m_slot_reg;
    logic      m_ev_valid_reg;
    page_t     m_ev_page_reg;
    stat_t     m_hits_reg, m_acc_reg;

    cnt_t      n_act;
    logic      last;
    logic      accept;
    logic      commit;
    logic      match;
    logic      evict;
    slot_t     sel_slot;
    slot_t     rd_idx;
    entry_rd_t rd_entry;
    scan_res_t res;
    upd_cmd_t  upd;
    stat_t     hit_cnt_inc, acc_cnt_inc;

    always_comb begin
        if (act_reg == '0) begin
            n_act = CNT_BITS'(1);
        end else if (int'(act_reg) > ENTRIES) begin
            n_act = CNT_BITS'(ENTRIES);
        end else begin
            n_act = CNT_BITS'(act_reg);
        end
    end

    assign last      = CNT_BITS'(idx_reg) == (n_act - CNT_BITS'(1));
    assign s_ready   = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign commit    = (state_reg == S_UPD) && (!m_valid_reg || m_ready);

    assign evict    = !res.hit && !res.empty;
    assign sel_slot = res.hit ? res.hit_idx : (res.empty ? res.empty_idx : res.best_idx);
    // during the update cycle the read port shows the old tag of the victim
    assign rd_idx   = (state_reg == S_UPD) ? sel_slot : idx_reg;

    assign upd.en   = commit;
    assign upd.hit  = res.hit;
    assign upd.slot = sel_slot;
    assign upd.page = page_reg;
    assign upd.n    = n_act;

    assign hit_cnt_inc = hit_cnt_reg + stat_t'(1);
    assign acc_cnt_inc = acc_cnt_reg + stat_t'(1);

    lpr_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry),
        .upd      (upd)
    );

    lpr_scan u_scan (
        .aclk     (aclk),
        .start    (accept),
        .step     (state_reg == S_SCAN),
        .idx      (idx_reg),
        .page     (page_reg),
        .rd_entry (rd_entry),
        .match    (match),
        .res      (res)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (match || last) begin
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                if (commit) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            act_reg     <= ACT_BITS'(ACT_RESET);
            hit_cnt_reg <= '0;
            acc_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                act_reg <= cfg_data;
            end
            if (commit) begin
                acc_cnt_reg <= acc_cnt_inc;
                if (res.hit) begin
                    hit_cnt_reg <= hit_cnt_inc;
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            page_reg <= s_page;
            idx_reg  <= '0;
        end else if (state_reg == S_SCAN) begin
            idx_reg <= idx_reg + slot_t'(1);
        end
        if (commit) begin
            m_hit_reg      <= res.hit;
            m_slot_reg     <= to_slot_out(sel_slot);
            m_ev_valid_reg <= evict;
            m_ev_page_reg  <= evict ? rd_entry.tag : '0;
            m_hits_reg     <= res.hit ? hit_cnt_inc : hit_cnt_reg;
            m_acc_reg      <= acc_cnt_inc;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_hit             = m_hit_reg;
    assign m_slot            = m_slot_reg;
    assign m_evicted_valid   = m_ev_valid_reg;
    assign m_evicted_page    = m_ev_page_reg;
    assign m_hits_so_far     = m_hits_reg;
    assign m_accesses_so_far = m_acc_reg;

    `ASSERT_NORST(a_rst_idle, aclk, !aresetn |=> (state_reg == S_IDLE) && !m_valid_reg)
    `ASSERT_CLK(a_out_from_upd, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg == S_UPD))
    `ASSERT_CLK(a_scan_range, aclk, aresetn, (state_reg == S_SCAN) |-> (CNT_BITS'(idx_reg) < n_act))
    `ASSERT_CLK(a_acc_step, aclk, aresetn, commit |=> acc_cnt_reg == $past(acc_cnt_reg) + stat_t'(1))
    `ASSERT_CLK(a_hit_no_evict, aclk, aresetn, m_valid_reg && m_hit_reg |-> !m_ev_valid_reg)

endmodule

[src/lpr_store.sv]
// Slot storage: tags, valid marks and recency ranks, with the LRU rank update.
// Depends on lpr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lpr_store (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lpr_pkg::slot_t       rd_idx,
    output lpr_pkg::entry_rd_t   rd_entry,
    input  lpr_pkg::upd_cmd_t    upd
);
    import lpr_pkg::*;

    page_t               tag_reg   [ENTRIES];
    logic [ENTRIES-1:0]  valid_reg;
    logic [ENTRIES-1:0]  valid_next;
    rank_t               rank_reg  [ENTRIES];
    rank_t               rank_next [ENTRIES];
    logic [RANK_BITS:0]  limit;

    assign rd_entry.valid = valid_reg[rd_idx];
    assign rd_entry.tag   = tag_reg[rd_idx];
    assign rd_entry.rank  = rank_reg[rd_idx];

    // a hit only ages entries younger than the one touched
    assign limit = upd.hit ? {1'b0, rank_reg[upd.slot]} : (RANK_BITS + 1)'(ENTRIES);

    always_comb begin
        valid_next = valid_reg;
        for (int i = 0; i < ENTRIES; i++) begin
            rank_next[i] = rank_reg[i];
            if (upd.en) begin
                if (SLOT_BITS'(i) == upd.slot) begin
                    rank_next[i]  = '0;
                    valid_next[i] = 1'b1;
                end else if ((CNT_BITS'(i) < upd.n) && valid_reg[i] &&
                             ({1'b0, rank_reg[i]} < limit) && (rank_reg[i] != RANK_MAX)) begin
                    rank_next[i] = rank_reg[i] + rank_t'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (upd.en && !upd.hit) begin
            tag_reg[upd.slot] <= upd.page;
        end
    end

    `ASSERT_CLK(a_upd_mru, aclk, aresetn, upd.en |=> valid_reg[$past(upd.slot)] && (rank_reg[$past(upd.slot)] == '0))

endmodule

[src/lpr_scan.sv]
// Scan unit: one slot per cycle, tracks first hit, first empty slot
// and the oldest entry. Depends on lpr_pkg.
module lpr_scan (
    input  logic                aclk,
    input  logic                start,
    input  logic                step,
    input  lpr_pkg::slot_t      idx,
    input  lpr_pkg::page_t      page,
    input  lpr_pkg::entry_rd_t  rd_entry,
    output logic                match,
    output lpr_pkg::scan_res_t  res
);
    import lpr_pkg::*;

    logic  hit_reg;
    slot_t hit_idx_reg;
    logic  empty_reg;
    slot_t empty_idx_reg;
    rank_t best_rank_reg;
    slot_t best_idx_reg;

    assign match = rd_entry.valid && (rd_entry.tag == page);

    assign res.hit       = hit_reg;
    assign res.hit_idx   = hit_idx_reg;
    assign res.empty     = empty_reg;
    assign res.empty_idx = empty_idx_reg;
    assign res.best_idx  = best_idx_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            empty_reg     <= 1'b0;
            empty_idx_reg <= '0;
            best_rank_reg <= '0;
            best_idx_reg  <= '0;
        end else if (step) begin
            if (match && !hit_reg) begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= idx;
            end
            if (!rd_entry.valid && !empty_reg) begin
                empty_reg     <= 1'b1;
                empty_idx_reg <= idx;
            end
            // strict compare keeps the lowest index on a tie
            if (rd_entry.rank > best_rank_reg) begin
                best_rank_reg <= rd_entry.rank;
                best_idx_reg  <= idx;
            end
        end
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for lru_page_replacement: random page accesses, checked against a true-LRU predictor.
// Depends on lpr_pkg and lru_page_replacement from the RTL sources.

// One access outcome as reported on the m_ channel
typedef struct {
    logic                  hit;
    lpr_pkg::slot_out_t    slot;
    logic                  evicted_valid;
    lpr_pkg::page_t        evicted_page;
    lpr_pkg::stat_t        hits_so_far;
    lpr_pkg::stat_t        accesses_so_far;
} access_outcome_t;

class page_store_scoreboard;
    lpr_pkg::page_t  tags [lpr_pkg::ENTRIES];
    bit              resident [lpr_pkg::ENTRIES];
    int unsigned     age_rank [lpr_pkg::ENTRIES];
    lpr_pkg::stat_t  hit_total;
    lpr_pkg::stat_t  access_total;
    lpr_pkg::act_t   active_setting;
    access_outcome_t pending_outcomes [$];
    int              errors;

    function new();
        for (int i = 0; i < lpr_pkg::ENTRIES; i++) begin
            tags[i]     = '0;
            resident[i] = 1'b0;
            age_rank[i] = 0;
        end
        hit_total      = '0;
        access_total   = '0;
        active_setting = lpr_pkg::ACT_RESET;
        errors         = 0;
    endfunction

    function void set_active(lpr_pkg::act_t v);
        active_setting = v;
    endfunction

    // 0 behaves as 1, anything above the built size as the built size
    function int active_slots();
        if (active_setting == 0)
            return 1;
        if (active_setting > lpr_pkg::ENTRIES)
            return lpr_pkg::ENTRIES;
        return active_setting;
    endfunction

    function int pending();
        return pending_outcomes.size();
    endfunction

    // Slot s becomes most recent; valid active entries younger than lim age by one
    function void promote(int s, int n, int unsigned lim);
        for (int i = 0; i < n; i++) begin
            if (i != s && resident[i] && age_rank[i] < lim &&
                age_rank[i] < lpr_pkg::ENTRIES - 1)
                age_rank[i]++;
        end
        age_rank[s] = 0;
    endfunction

    function void record_access(lpr_pkg::page_t pg);
        access_outcome_t o;
        int              n;
        int              s;
        bit              found;
        bit              empty;
        int unsigned     oldest;
        n            = active_slots();
        s            = 0;
        found        = 1'b0;
        empty        = 1'b0;
        o.evicted_valid = 1'b0;
        o.evicted_page  = '0;
        access_total++;
        for (int i = 0; i < n && !found; i++) begin
            if (resident[i] && tags[i] == pg) begin
                s     = i;
                found = 1'b1;
            end
        end
        if (found) begin
            hit_total++;
            promote(s, n, age_rank[s]);
        end else begin
            for (int i = 0; i < n && !empty; i++) begin
                if (!resident[i]) begin
                    s     = i;
                    empty = 1'b1;
                end
            end
            if (!empty) begin
                // highest rank wins, lowest index on a tie
                oldest = 0;
                s      = 0;
                for (int i = 0; i < n; i++) begin
                    if (age_rank[i] > oldest) begin
                        oldest = age_rank[i];
                        s      = i;
                    end
                end
                o.evicted_valid = 1'b1;
                o.evicted_page  = tags[s];
            end
            tags[s] = pg;
            promote(s, n, lpr_pkg::ENTRIES);
            resident[s] = 1'b1;
        end
        o.hit             = found;
        o.slot            = lpr_pkg::slot_out_t'(s);
        o.hits_so_far     = hit_total;
        o.accesses_so_far = access_total;
        pending_outcomes.push_back(o);
    endfunction

    function void check_outcome(access_outcome_t got);
        access_outcome_t want;
        if (pending_outcomes.size() == 0) begin
            $display("%0t: result beat with nothing expected", $time);
            errors++;
            return;
        end
        want = pending_outcomes.pop_front();
        if (got.hit !== want.hit) begin
            $display("%0t: hit exp %h got %h", $time, want.hit, got.hit);
            errors++;
        end
        if (got.slot !== want.slot) begin
            $display("%0t: slot exp %h got %h", $time, want.slot, got.slot);
            errors++;
        end
        if (got.evicted_valid !== want.evicted_valid) begin
            $display("%0t: evicted_valid exp %h got %h", $time,
                     want.evicted_valid, got.evicted_valid);
            errors++;
        end
        if (got.evicted_page !== want.evicted_page) begin
            $display("%0t: evicted_page exp %h got %h", $time,
                     want.evicted_page, got.evicted_page);
            errors++;
        end
        if (got.hits_so_far !== want.hits_so_far) begin
            $display("%0t: hits_so_far exp %h got %h", $time,
                     want.hits_so_far, got.hits_so_far);
            errors++;
        end
        if (got.accesses_so_far !== want.accesses_so_far) begin
            $display("%0t: accesses_so_far exp %h got %h", $time,
                     want.accesses_so_far, got.accesses_so_far);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import lpr_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 200;

    logic      aclk              = 1'b0;
    logic      aresetn           = 1'b0;
    logic      s_valid           = 1'b0;
    logic      s_ready;
    page_t     s_page            = '0;
    logic      m_valid;
    logic      m_ready           = 1'b0;
    logic      m_hit;
    slot_out_t m_slot;
    logic      m_evicted_valid;
    page_t     m_evicted_page;
    stat_t     m_hits_so_far;
    stat_t     m_accesses_so_far;
    logic      cfg_valid         = 1'b0;
    logic      cfg_ready;
    act_t      cfg_data          = '0;

    page_store_scoreboard sb;
    bit tx_gaps      = 1'b1;
    bit rx_gaps      = 1'b1;
    bit hold_request = 1'b0;
    int stall_cycles = 0;

    lru_page_replacement u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_page            (s_page),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_hit             (m_hit),
        .m_slot            (m_slot),
        .m_evicted_valid   (m_evicted_valid),
        .m_evicted_page    (m_evicted_page),
        .m_hits_so_far     (m_hits_so_far),
        .m_accesses_so_far (m_accesses_so_far),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    always #5 aclk = ~aclk;

    task automatic send_page(input page_t pg);
        int gap;
        if (tx_gaps && $urandom_range(99) < 25) begin
            gap = $urandom_range(24, 1);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_page  <= pg;
        do @(posedge aclk); while (!s_ready);
        sb.record_access(pg);
    endtask

    // Stop offering accesses and wait for every outstanding result
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_active(input act_t v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_active(v);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random back-pressure plus one long hold-off on request
    initial begin : result_side
        int hold_left;
        access_outcome_t got;
        hold_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !rx_gaps || ($urandom_range(99) >= 25);
            end
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got.hit             = m_hit;
                got.slot            = m_slot;
                got.evicted_valid   = m_evicted_valid;
                got.evicted_page    = m_evicted_page;
                got.hits_so_far     = m_hits_so_far;
                got.accesses_so_far = m_accesses_so_far;
                sb.check_outcome(got);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_cycles <= 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready) ||
                     (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        act_t  settings [8];
        page_t pool [32];
        page_t pg;
        int    pool_size;
        sb = new();
        settings = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd0, 5'd17, 5'd8, 5'd2};
        settings[7] = act_t'($urandom_range(31));
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // fill from empty, hits on both extremes of the page field
        send_page(20'h00000);
        send_page(20'hFFFFF);
        send_page(20'h00000);
        send_page(20'hFFFFF);
        send_page(20'h55555);
        send_page(20'hAAAAA);
        // shrink: slots above the active count keep their pages but are not seen
        write_active(5'd2);
        send_page(20'h55555);
        send_page(20'h55555);
        send_page(20'hAAAAA);
        send_page(20'h00000);
        // zero acts as one slot
        write_active(5'd0);
        send_page(20'h12345);
        send_page(20'h12345);
        send_page(20'hFEDCB);
        // above the built size acts as full size; old inactive entries come back
        write_active(5'd31);
        send_page(20'hAAAAA);
        send_page(20'h00000);
        send_page(20'hFFFFF);
        send_page(20'h0F0F0);
        write_active(5'd17);
        send_page(20'hFEDCB);
        send_page(20'h55555);

        for (int ph = 0; ph < 8; ph++) begin
            write_active(settings[ph]);
            tx_gaps = (ph != 2);
            rx_gaps = (ph != 2);
            if (ph == 4)
                hold_request = 1'b1;
            // working set a little larger than the store gives hits and evictions
            pool_size = sb.active_slots() + $urandom_range(6, 1);
            for (int i = 0; i < pool_size; i++)
                pool[i] = page_t'($urandom);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(99) < 85)
                    pg = pool[$urandom_range(pool_size - 1)];
                else
                    pg = page_t'($urandom);
                send_page(pg);
            end
        end

        drain_results();
        repeat (2 * ENTRIES + 4) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[lru_page_replacement.f]
+incdir+src
src/lpr_pkg.sv
src/lpr_store.sv
src/lpr_scan.sv
src/lru_page_replacement.sv
sim/tb_top.sv
